### hw/rtl/c2p_pkg.sv
package c2p_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int MAG_WIDTH     = 16;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 24;
  localparam int ZSCALE_BITS   = 24;
  localparam int ATAN_WIDTH    = 32;

  localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic signed [ATAN_WIDTH-1:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234683,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [MAG_WIDTH-1:0]   magnitude;
    logic [ANGLE_WIDTH-1:0] angle_deg;
  } out_item_t;

endpackage

### hw/rtl/cartesian_to_polar.sv
// Cartesian to polar converter. Each transaction carries one signed (x, y) pair and returns
// its length, rounded to the nearest integer, and its direction in 1/2^ANGLE_FRAC_BITS
// degree, 0 up to just under 360, taken from a 24-stage CORDIC in vectoring mode; x equal
// to zero gives exactly 90 degrees for positive y and 270 otherwise, the origin included.
// One transaction is accepted every clock while the output buffer is not full. The path
// from input to output runs through the registers for input conditioning, squaring and
// summing, the CORDIC rotation stages (the magnitude runs a restoring square root, one
// result bit per cycle, beside it), the registers for quadrant correction and rounding,
// and the output register. A two-entry output buffer keeps the pipeline moving while a
// result waits; a stall on the output freezes the whole pipeline without loss.
module cartesian_to_polar #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  c2p_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output c2p_pkg::out_item_t   out_data_o
);

  import c2p_pkg::*;

  localparam int CW         = COORD_WIDTH;
  localparam int NW         = 2 * CW;
  localparam int SQRT_STEPS = CW;
  localparam int NSTG       = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int AW         = CW + ZSCALE_BITS + 3;
  localparam int ZW         = ATAN_WIDTH;
  localparam int TW         = ZW + 2;
  localparam int RSH        = ZSCALE_BITS - ANGLE_FRAC_BITS;
  localparam int QW         = TW - RSH;
  localparam int MW         = CW + 1;

  localparam logic [TW-1:0] DEG180 = TW'(180) << ZSCALE_BITS;
  localparam logic [TW-1:0] DEG360 = TW'(360) << ZSCALE_BITS;
  localparam logic [TW-1:0] HALF   = TW'(1) << (RSH - 1);
  localparam logic [QW-1:0] FULL   = QW'(360) << ANGLE_FRAC_BITS;
  localparam logic [QW-1:0] ANG90  = QW'(90) << ANGLE_FRAC_BITS;
  localparam logic [QW-1:0] ANG270 = QW'(270) << ANGLE_FRAC_BITS;

  typedef struct packed {
    logic signed [AW-1:0] cx;
    logic signed [AW-1:0] cy;
    logic                 neg;
    logic                 xz;
    logic                 yp;
    logic [NW-1:0]        a;
    logic [NW-1:0]        b;
  } pre_t;

  typedef struct packed {
    logic signed [AW-1:0] cx;
    logic signed [AW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic                 neg;
    logic                 xz;
    logic                 yp;
    logic [NW-1:0]        rem;
    logic [NW-1:0]        root;
  } stg_t;

  logic en;
  logic push;
  logic pop;

  pre_t p0_d, p0_q, p1_d, p1_q;
  logic p0_v_q, p1_v_q;

  stg_t stg_q [NSTG+1];
  logic sv_q  [NSTG+1];

  logic [TW-1:0] f0_total_q;
  logic          f0_xz_q, f0_yp_q, f0_v_q;
  logic [MW-1:0] f0_mag_q;

  logic [QW-1:0]        f1_q_q;
  logic                 f1_xz_q, f1_yp_q, f1_v_q;
  logic [MAG_WIDTH-1:0] f1_mag_q;

  out_item_t res;
  out_item_t out_q, skid_q;
  logic [1:0] cnt_q, cnt_d;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  // input conditioning
  always_comb begin
    logic signed [CW:0] xs, ys, xn, yn, xa, ya;
    xs = {in_data_i.x_coord[CW-1], in_data_i.x_coord};
    ys = {in_data_i.y_coord[CW-1], in_data_i.y_coord};
    xa = xs[CW] ? -xs : xs;
    ya = ys[CW] ? -ys : ys;
    xn = xs[CW] ? -xs : xs;
    yn = xs[CW] ? -ys : ys;
    p0_d.neg = xs[CW];
    p0_d.xz  = (xs == '0);
    p0_d.yp  = !ys[CW] && (ys != '0);
    p0_d.cx  = {{(AW-CW-1-ZSCALE_BITS){xn[CW]}}, xn, {ZSCALE_BITS{1'b0}}};
    p0_d.cy  = {{(AW-CW-1-ZSCALE_BITS){yn[CW]}}, yn, {ZSCALE_BITS{1'b0}}};
    p0_d.a   = NW'(xa[CW-1:0]);
    p0_d.b   = NW'(ya[CW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      sv_q[0] <= 1'b0;
    end else if (en) begin
      p0_v_q  <= in_valid_i;
      p1_v_q  <= p0_v_q;
      sv_q[0] <= p1_v_q;
    end
  end

  // squares, then their sum
  always_comb begin
    p1_d   = p0_q;
    p1_d.a = p0_q.a * p0_q.a;
    p1_d.b = p0_q.b * p0_q.b;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q      <= p0_d;
      p1_q      <= p1_d;
      stg_q[0]  <= '{cx: p1_q.cx, cy: p1_q.cy, z: '0, neg: p1_q.neg, xz: p1_q.xz,
                     yp: p1_q.yp, rem: p1_q.a + p1_q.b, root: '0};
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic signed [AW-1:0] cx, cy, cx_n, cy_n;
    logic signed [ZW-1:0] z, z_n;
    logic [NW-1:0]        rem, root, rem_n, root_n;

    assign cx   = stg_q[k].cx;
    assign cy   = stg_q[k].cy;
    assign z    = stg_q[k].z;
    assign rem  = stg_q[k].rem;
    assign root = stg_q[k].root;

    if (k < CORDIC_STAGES) begin : g_rot
      logic signed [AW-1:0] dx, dy;
      assign dx   = cy >>> k;
      assign dy   = cx >>> k;
      assign cx_n = cy[AW-1] ? cx - dx : cx + dx;
      assign cy_n = cy[AW-1] ? cy + dy : cy - dy;
      assign z_n  = cy[AW-1] ? z - ATAN_TAB[k] : z + ATAN_TAB[k];
    end else begin : g_rot_pass
      assign cx_n = cx;
      assign cy_n = cy;
      assign z_n  = z;
    end

    if (k < SQRT_STEPS) begin : g_sqrt
      localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
      logic [NW:0] t, diff;
      logic        ge;
      assign t      = {1'b0, root} + {1'b0, BIT};
      assign ge     = ({1'b0, rem} >= t);
      assign diff   = {1'b0, rem} - t;
      assign rem_n  = ge ? diff[NW-1:0] : rem;
      assign root_n = ge ? (root >> 1) + BIT : (root >> 1);
    end else begin : g_sqrt_pass
      assign rem_n  = rem;
      assign root_n = root;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[k+1] <= '{cx: cx_n, cy: cy_n, z: z_n, neg: stg_q[k].neg, xz: stg_q[k].xz,
                        yp: stg_q[k].yp, rem: rem_n, root: root_n};
      end
    end
  end

  // quadrant correction, rounding and saturation
  logic [ZW-1:0] zt;
  logic [TW-1:0] sel;
  logic [TW-1:0] rnd;
  logic [QW-1:0] qw, ang;
  logic [MW-1:0] mag_r;

  always_comb begin
    zt = stg_q[NSTG].z;
    if (stg_q[NSTG].neg) begin
      sel = DEG180;
    end else if (stg_q[NSTG].z[ZW-1]) begin
      sel = DEG360;
    end else begin
      sel = '0;
    end
    mag_r = stg_q[NSTG].root[MW-1:0] + MW'(stg_q[NSTG].rem > stg_q[NSTG].root);
    rnd   = f0_total_q + HALF;
    qw    = (f1_q_q >= FULL) ? f1_q_q - FULL : f1_q_q;
    if (f1_xz_q) begin
      ang = f1_yp_q ? ANG90 : ANG270;
    end else begin
      ang = qw;
    end
    res.magnitude = f1_mag_q;
    res.angle_deg = ANGLE_WIDTH'(ang);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
    end else if (en) begin
      f0_v_q <= sv_q[NSTG];
      f1_v_q <= f0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_total_q <= {{(TW-ZW){zt[ZW-1]}}, zt} + sel;
      f0_xz_q    <= stg_q[NSTG].xz;
      f0_yp_q    <= stg_q[NSTG].yp;
      f0_mag_q   <= mag_r;
      f1_q_q     <= rnd[TW-1:RSH];
      f1_xz_q    <= f0_xz_q;
      f1_yp_q    <= f0_yp_q;
      f1_mag_q   <= (32'(f0_mag_q) > 32'(MAG_MAX)) ? MAG_MAX : MAG_WIDTH'(f0_mag_q);
    end
  end

  // output register with skid entry
  assign push        = en && f1_v_q;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = out_q;

  always_comb begin
    case (cnt_q)
      2'd0:    cnt_d = push ? 2'd1 : 2'd0;
      2'd1:    cnt_d = (push && !pop) ? 2'd2 : ((!push && pop) ? 2'd0 : 2'd1);
      2'd2:    cnt_d = pop ? 2'd1 : 2'd2;
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop))) begin
      out_q <= res;
    end else if (push && cnt_q == 2'd1) begin
      skid_q <= res;
    end else if (pop && cnt_q == 2'd2) begin
      out_q <= skid_q;
    end
  end

endmodule
